// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== hw/rtl/rcpc_pkg.sv =====
// ----------------------------------------------------------------------------
// rcpc_pkg
// Types and constants shared by the ray / convex solid clipping block.
// ----------------------------------------------------------------------------
package rcpc_pkg;

    localparam int WORD_W  = 48;
    localparam int TOL_W   = WORD_W - 1;
    localparam int CHUNK_W = 16;
    localparam int N_CHUNK = (WORD_W + CHUNK_W - 1) / CHUNK_W;
    localparam int TERMS   = 3;
    localparam int ACC_W   = 2 * WORD_W + 3;
    localparam int PROD_W  = WORD_W + CHUNK_W + 1;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        logic  kind;
        word_t vec_x;
        word_t vec_y;
        word_t vec_z;
        word_t dir_x;
        word_t dir_y;
        word_t dir_z;
        word_t plane_offset;
        word_t enter_start;
        word_t leave_start;
        logic  negate_tol;
        logic  last_plane;
    } in_item_t;

    typedef struct packed {
        logic  hit;
        word_t enter_dist;
        word_t leave_dist;
    } out_item_t;

    localparam logic KIND_BEGIN = 1'b0;
    localparam logic KIND_PLANE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EVAL,
        ST_DECIDE,
        ST_DIV,
        ST_CHECK,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic       load_begin;
        logic       load_plane;
        logic       mul_en;
        logic [1:0] term;
        logic [1:0] chunk;
        logic       eval;
        logic       par_test;
        logic       div_start;
        logic       update;
        logic       check;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic rejected;
        logic parallel;
        logic last;
        logic div_done;
        logic out_busy;
    } status_t;

endpackage

// ===== hw/rtl/ray_convex_polyhedron_clip.sv =====
// A begin beat is taken in idle and only loads the ray. A plane beat steps through
// accept, the MAC passes (3 terms x 3 chunk products of 48x17 bits), drain,
// evaluation, decide, the divide, the interval check and finish; a new beat is
// taken only back in idle. Parallel planes skip the divider, a plane for a rejected
// ray goes straight to finish, and a held result stalls the last plane.
// Reset (synchronous, aresetn low) zeroes the ray state, sets tolerance to 66.
// ----------------------------------------------------------------------------
// ray_convex_polyhedron_clip
// Clips a ray against a convex solid given as a stream of bounding planes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ray_convex_polyhedron_clip #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  rcpc_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output rcpc_pkg::out_item_t         m_data,
    input  logic                        cfg_we,
    input  logic [rcpc_pkg::TOL_W-1:0]  cfg_wdata
);
    import rcpc_pkg::*;

    cmd_t    cmd;
    status_t status;

    rcpc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_data.kind),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rcpc_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // result sanity
    `ASSERT_IMPLY(a_miss_zero, aclk, aresetn, m_valid && !m_data.hit, m_data.enter_dist == 0 && m_data.leave_dist == 0)
    `ASSERT_IMPLY(a_hit_order, aclk, aresetn, m_valid && m_data.hit, m_data.leave_dist > m_data.enter_dist)
    `ASSERT_NEVER(a_enter_neg, aclk, aresetn, m_valid && m_data.enter_dist < 0)
    `ASSERT_NEVER(a_emit_busy, aclk, aresetn, cmd.emit && m_valid && !m_ready)

endmodule

// ===== hw/rtl/rcpc_div.sv =====
// ----------------------------------------------------------------------------
// rcpc_div
// Restoring divider: (num << FRAC_BITS) / den, truncated toward zero and
// saturated to a word. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcpc_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  rcpc_pkg::word_t num,
    input  rcpc_pkg::word_t den,
    output logic          done,
    output rcpc_pkg::word_t quo
);
    import rcpc_pkg::*;

    localparam int QW    = WORD_W + FRAC_BITS;
    localparam int CNT_W = $clog2(QW);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [QW-1:0]    n_reg;
    logic [QW-1:0]    q_reg;
    logic [WORD_W-1:0] r_reg;
    logic [WORD_W-1:0] d_reg;
    logic             neg_reg;

    logic [WORD_W-1:0] num_mag;
    logic [WORD_W-1:0] den_mag;
    logic [WORD_W:0]   r_shift;
    logic              ge;
    logic [WORD_W:0]   r_sub;

    assign num_mag = num[WORD_W-1] ? WORD_W'(-num) : WORD_W'(num);
    assign den_mag = den[WORD_W-1] ? WORD_W'(-den) : WORD_W'(den);
    assign r_shift = {r_reg, n_reg[QW-1]};
    assign ge      = r_shift >= {1'b0, d_reg};
    assign r_sub   = r_shift - {1'b0, d_reg};

    // control: busy and finish pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(QW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one restoring step per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg   <= {num_mag, {FRAC_BITS{1'b0}}};
            q_reg   <= '0;
            r_reg   <= '0;
            d_reg   <= den_mag;
            neg_reg <= num[WORD_W-1] ^ den[WORD_W-1];
        end else if (busy_reg) begin
            n_reg <= {n_reg[QW-2:0], 1'b0};
            q_reg <= {q_reg[QW-2:0], ge};
            r_reg <= ge ? r_sub[WORD_W-1:0] : r_shift[WORD_W-1:0];
        end
    end

    // sign and saturate
    always_comb begin
        if (!neg_reg) begin
            if (q_reg > QW'({1'b0, {(WORD_W-1){1'b1}}}))
                quo = {1'b0, {(WORD_W-1){1'b1}}};
            else
                quo = word_t'(q_reg[WORD_W-1:0]);
        end else begin
            if (q_reg > QW'({1'b1, {(WORD_W-1){1'b0}}}))
                quo = {1'b1, {(WORD_W-1){1'b0}}};
            else
                quo = word_t'(-q_reg[WORD_W-1:0]);
        end
    end

    assign done = done_reg;

endmodule

// ===== hw/rtl/rcpc_datapath.sv =====
// ----------------------------------------------------------------------------
// rcpc_datapath
// Ray state, chunked dot-product MACs, divider, interval update and the
// output register.
// ----------------------------------------------------------------------------
module rcpc_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rcpc_pkg::cmd_t              cmd,
    output rcpc_pkg::status_t           status,
    input  rcpc_pkg::in_item_t          s_data,
    input  logic                        cfg_we,
    input  logic [rcpc_pkg::TOL_W-1:0]  cfg_wdata,
    output logic                        m_valid,
    input  logic                        m_ready,
    output rcpc_pkg::out_item_t         m_data
);
    import rcpc_pkg::*;

    localparam int    EPS_INT = (2**FRAC_BITS + 500) / 1000;
    localparam word_t PAR_EPS = word_t'(EPS_INT);

    word_t org_reg [TERMS];
    word_t dir_reg [TERMS];
    word_t nrm_reg [TERMS];
    word_t entry_reg;
    word_t exit_reg;
    logic  rej_reg;
    logic  tneg_reg;
    logic  last_reg;
    logic [TOL_W-1:0] tol_reg;

    logic signed [PROD_W-1:0] prod_n_reg;
    logic signed [PROD_W-1:0] prod_c_reg;
    logic [1:0]               shift_reg;
    logic                     pend_reg;
    logic signed [ACC_W-1:0]  acc_n_reg;
    logic signed [ACC_W-1:0]  acc_c_reg;
    word_t                    numer_reg;
    word_t                    cos_reg;

    out_item_t out_reg;
    logic      mval_reg;

    logic [CHUNK_W-1:0]      slice;
    logic signed [CHUNK_W:0] bmul;
    logic signed [ACC_W-1:0] pn_sh;
    logic signed [ACC_W-1:0] pc_sh;
    word_t                   tolw;
    word_t                   te;
    word_t                   quo;
    logic                    div_done;
    logic signed [WORD_W:0]  ent_tol;

    function automatic word_t sat_word(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] sh;
        sh = v >>> FRAC_BITS;
        if (&sh[ACC_W-1:WORD_W-1] || ~|sh[ACC_W-1:WORD_W-1])
            return word_t'(sh[WORD_W-1:0]);
        else if (sh[ACC_W-1])
            return {1'b1, {(WORD_W-1){1'b0}}};
        else
            return {1'b0, {(WORD_W-1){1'b1}}};
    endfunction

    // multiplier operand: one chunk of the normal, top chunk signed
    assign slice = nrm_reg[cmd.term][cmd.chunk*CHUNK_W +: CHUNK_W];
    assign bmul  = (cmd.chunk == 2'(N_CHUNK - 1)) ?
                   {nrm_reg[cmd.term][WORD_W-1], slice} : {1'b0, slice};

    // align the registered partial products
    always_comb begin
        unique case (shift_reg)
            2'd0:    begin
                pn_sh = ACC_W'(prod_n_reg);
                pc_sh = ACC_W'(prod_c_reg);
            end
            2'd1:    begin
                pn_sh = ACC_W'(prod_n_reg) <<< CHUNK_W;
                pc_sh = ACC_W'(prod_c_reg) <<< CHUNK_W;
            end
            2'd2:    begin
                pn_sh = ACC_W'(prod_n_reg) <<< (2 * CHUNK_W);
                pc_sh = ACC_W'(prod_c_reg) <<< (2 * CHUNK_W);
            end
            default: begin
                pn_sh = ACC_W'(prod_n_reg) <<< (3 * CHUNK_W);
                pc_sh = ACC_W'(prod_c_reg) <<< (3 * CHUNK_W);
            end
        endcase
    end

    assign tolw    = word_t'({1'b0, tol_reg});
    assign te      = tneg_reg ? -tolw : tolw;
    assign ent_tol = {entry_reg[WORD_W-1], entry_reg} + {2'b00, tol_reg};

    // divider
    rcpc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (numer_reg),
        .den     (cos_reg),
        .done    (div_done),
        .quo     (quo)
    );

    // products and accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= cmd.mul_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_n_reg <= org_reg[cmd.term] * bmul;
            prod_c_reg <= dir_reg[cmd.term] * bmul;
            shift_reg  <= cmd.chunk;
        end
        if (cmd.load_plane) begin
            acc_n_reg <= ACC_W'(s_data.plane_offset) <<< FRAC_BITS;
            acc_c_reg <= '0;
        end else if (pend_reg) begin
            acc_n_reg <= acc_n_reg - pn_sh;
            acc_c_reg <= acc_c_reg + pc_sh;
        end
        if (cmd.eval) begin
            numer_reg <= sat_word(acc_n_reg);
            cos_reg   <= sat_word(acc_c_reg);
        end
        if (cmd.load_plane) begin
            nrm_reg[0] <= s_data.vec_x;
            nrm_reg[1] <= s_data.vec_y;
            nrm_reg[2] <= s_data.vec_z;
        end
    end

    // ray state and interval
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TERMS; i++) begin
                org_reg[i] <= '0;
                dir_reg[i] <= '0;
            end
            entry_reg <= '0;
            exit_reg  <= '0;
            rej_reg   <= 1'b0;
            tneg_reg  <= 1'b0;
            last_reg  <= 1'b0;
            tol_reg   <= TOL_RESET;
        end else begin
            if (cfg_we)
                tol_reg <= cfg_wdata;
            if (cmd.load_begin) begin
                org_reg[0] <= s_data.vec_x;
                org_reg[1] <= s_data.vec_y;
                org_reg[2] <= s_data.vec_z;
                dir_reg[0] <= s_data.dir_x;
                dir_reg[1] <= s_data.dir_y;
                dir_reg[2] <= s_data.dir_z;
                entry_reg  <= s_data.enter_start;
                exit_reg   <= s_data.leave_start;
                tneg_reg   <= s_data.negate_tol;
                rej_reg    <= 1'b0;
            end
            if (cmd.load_plane)
                last_reg <= s_data.last_plane;
            if (cmd.par_test && (numer_reg > te))
                rej_reg <= 1'b1;
            if (cmd.update) begin
                if (cos_reg > 0) begin
                    if (quo > entry_reg)
                        entry_reg <= quo;
                end else begin
                    if (quo < exit_reg)
                        exit_reg <= quo;
                end
            end
            if (cmd.check) begin
                if (!(ent_tol < $signed({exit_reg[WORD_W-1], exit_reg})) ||
                    (exit_reg <= tolw))
                    rej_reg <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mval_reg <= 1'b0;
        end else if (cmd.emit) begin
            mval_reg <= 1'b1;
        end else if (m_ready) begin
            mval_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_reg.hit        <= !rej_reg;
            out_reg.enter_dist <= (rej_reg || entry_reg < 0) ? '0 : entry_reg;
            out_reg.leave_dist <= rej_reg ? '0 : exit_reg;
        end
    end

    assign m_valid = mval_reg;
    assign m_data  = out_reg;

    assign status.rejected = rej_reg;
    assign status.parallel = !((cos_reg > PAR_EPS) || (cos_reg < -PAR_EPS));
    assign status.last     = last_reg;
    assign status.div_done = div_done;
    assign status.out_busy = mval_reg && !m_ready;

endmodule

// ===== hw/rtl/rcpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcpc_ctrl
// Sequencer: accepts beats, steps the MAC passes, the divide and the
// interval checks, and launches the result.
// ----------------------------------------------------------------------------
module rcpc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_kind,
    output logic              s_ready,
    input  rcpc_pkg::status_t status,
    output rcpc_pkg::cmd_t    cmd
);
    import rcpc_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] term_reg, term_next;
    logic [1:0] chunk_reg, chunk_next;
    logic       accept;
    logic       mac_last;

    assign accept   = s_valid && (state_reg == ST_IDLE);
    assign mac_last = (term_reg == 2'(TERMS - 1)) && (chunk_reg == 2'(N_CHUNK - 1));

    // state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            term_reg  <= '0;
            chunk_reg <= '0;
        end else begin
            state_reg <= state_next;
            term_reg  <= term_next;
            chunk_reg <= chunk_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        term_next  = term_reg;
        chunk_next = chunk_reg;
        unique case (state_reg)
            ST_IDLE: begin
                term_next  = '0;
                chunk_next = '0;
                if (accept && s_kind == KIND_PLANE)
                    state_next = status.rejected ? ST_FIN : ST_MAC;
            end
            ST_MAC: begin
                if (chunk_reg == 2'(N_CHUNK - 1)) begin
                    chunk_next = '0;
                    term_next  = term_reg + 2'd1;
                end else begin
                    chunk_next = chunk_reg + 2'd1;
                end
                if (mac_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:  state_next = ST_EVAL;
            ST_EVAL:   state_next = ST_DECIDE;
            ST_DECIDE: state_next = status.parallel ? ST_CHECK : ST_DIV;
            ST_DIV: begin
                if (status.div_done)
                    state_next = ST_CHECK;
            end
            ST_CHECK:  state_next = ST_FIN;
            ST_FIN: begin
                if (!status.last || !status.out_busy)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd            = '0;
        cmd.term       = term_reg;
        cmd.chunk      = chunk_reg;
        cmd.load_begin = accept && (s_kind == KIND_BEGIN);
        cmd.load_plane = accept && (s_kind == KIND_PLANE);
        cmd.mul_en     = (state_reg == ST_MAC);
        cmd.eval       = (state_reg == ST_EVAL);
        cmd.par_test   = (state_reg == ST_DECIDE) && status.parallel;
        cmd.div_start  = (state_reg == ST_DECIDE) && !status.parallel;
        cmd.update     = (state_reg == ST_DIV) && status.div_done;
        cmd.check      = (state_reg == ST_CHECK);
        cmd.emit       = (state_reg == ST_FIN) && status.last && !status.out_busy;
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule
